>>> rtl/nss_pkg.sv
// ============================================================================
// nss_pkg
// Shared types and constants for the nearest segment search block.
// ============================================================================
package nss_pkg;

    localparam int DIST_BITS  = 25;
    localparam int DIR_BITS   = 16;
    localparam int KIND_BITS  = 4;
    localparam int DIR_STEPS  = 15;
    localparam int DIR_SHIFT  = 30;

    localparam logic [DIST_BITS-1:0]       DIST_MAX = '1;
    localparam logic signed [DIR_BITS-1:0] DIR_ONE  = 16'sd16384;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic                 has_seg;
        logic                 first;
        logic                 last;
        logic                 perp;
    } item_ctrl_t;

    localparam int CTRL_BITS = $bits(item_ctrl_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_DIRX,
        ST_DIRY,
        ST_DONE
    } back_state_t;

endpackage

>>> rtl/nss_front.sv
// ============================================================================
// nss_front
// Three-stage pipeline that forms the dot, cross and squared-length terms of
// a segment against the query point and classifies the nearest feature.
// ============================================================================
module nss_front #(
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] query_x,
    input  logic signed [COORD_BITS-1:0] query_y,
    input  logic signed [COORD_BITS-1:0] seg_ax,
    input  logic signed [COORD_BITS-1:0] seg_ay,
    input  logic signed [COORD_BITS-1:0] seg_bx,
    input  logic signed [COORD_BITS-1:0] seg_by,
    input  logic [nss_pkg::KIND_BITS-1:0] road_kind,
    input  logic                         has_segment,
    input  logic                         first_item,
    input  logic                         last_item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [4*(2*COORD_BITS+2)+2+nss_pkg::CTRL_BITS-1:0] out_data
);

    localparam int DFW = COORD_BITS + 1;
    localparam int MW  = 2 * COORD_BITS + 2;
    localparam int SW  = MW + 1;

    logic en;

    logic                    v1_reg, v2_reg, v3_reg;
    nss_pkg::item_ctrl_t     ctrl1_reg, ctrl2_reg, ctrl3_reg;
    logic signed [DFW-1:0]   vx_reg, vy_reg, wx_reg, wy_reg, ex_reg, ey_reg;
    logic signed [MW-1:0]    p_wxvx_reg, p_wyvy_reg, p_vxvx_reg, p_vyvy_reg;
    logic signed [MW-1:0]    p_wxwx_reg, p_wywy_reg, p_exex_reg, p_eyey_reg;
    logic signed [MW-1:0]    p_vxwy_reg, p_vywx_reg;
    logic                    sx2_reg, sy2_reg, sx3_reg, sy3_reg;
    logic signed [SW-1:0]    c1_reg, cr_reg;
    logic [MW-1:0]           c2_reg, sa_reg, sb_reg, vx2_reg, vy2_reg;

    logic signed [SW-1:0]    cr_abs;
    logic                    perp;
    logic [MW-1:0]           root_val;
    nss_pkg::item_ctrl_t     ctrl_out;

    assign en       = !v3_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_reg            <= DFW'(seg_bx) - DFW'(seg_ax);
            vy_reg            <= DFW'(seg_by) - DFW'(seg_ay);
            wx_reg            <= DFW'(query_x) - DFW'(seg_ax);
            wy_reg            <= DFW'(query_y) - DFW'(seg_ay);
            ex_reg            <= DFW'(query_x) - DFW'(seg_bx);
            ey_reg            <= DFW'(query_y) - DFW'(seg_by);
            ctrl1_reg.kind    <= road_kind;
            ctrl1_reg.has_seg <= has_segment;
            ctrl1_reg.first   <= first_item;
            ctrl1_reg.last    <= last_item;
            ctrl1_reg.perp    <= 1'b0;

            p_wxvx_reg <= MW'(wx_reg) * MW'(vx_reg);
            p_wyvy_reg <= MW'(wy_reg) * MW'(vy_reg);
            p_vxvx_reg <= MW'(vx_reg) * MW'(vx_reg);
            p_vyvy_reg <= MW'(vy_reg) * MW'(vy_reg);
            p_wxwx_reg <= MW'(wx_reg) * MW'(wx_reg);
            p_wywy_reg <= MW'(wy_reg) * MW'(wy_reg);
            p_exex_reg <= MW'(ex_reg) * MW'(ex_reg);
            p_eyey_reg <= MW'(ey_reg) * MW'(ey_reg);
            p_vxwy_reg <= MW'(vx_reg) * MW'(wy_reg);
            p_vywx_reg <= MW'(vy_reg) * MW'(wx_reg);
            sx2_reg    <= vx_reg[DFW-1];
            sy2_reg    <= vy_reg[DFW-1];
            ctrl2_reg  <= ctrl1_reg;

            c1_reg    <= SW'(p_wxvx_reg) + SW'(p_wyvy_reg);
            cr_reg    <= SW'(p_vxwy_reg) - SW'(p_vywx_reg);
            c2_reg    <= p_vxvx_reg + p_vyvy_reg;
            sa_reg    <= p_wxwx_reg + p_wywy_reg;
            sb_reg    <= p_exex_reg + p_eyey_reg;
            vx2_reg   <= p_vxvx_reg;
            vy2_reg   <= p_vyvy_reg;
            sx3_reg   <= sx2_reg;
            sy3_reg   <= sy2_reg;
            ctrl3_reg <= ctrl2_reg;
        end
    end

    always_comb
    begin
        cr_abs = cr_reg[SW-1] ? -cr_reg : cr_reg;
        perp   = (c1_reg > 0) && ($signed({1'b0, c2_reg}) > c1_reg);
        if (perp)
        begin
            root_val = cr_abs[MW-1:0];
        end
        else if (c1_reg > 0)
        begin
            root_val = sb_reg;
        end
        else
        begin
            root_val = sa_reg;
        end
        ctrl_out      = ctrl3_reg;
        ctrl_out.perp = perp;
    end

    assign out_valid = v3_reg;
    assign out_data  = {ctrl_out, sy3_reg, sx3_reg, vy2_reg, vx2_reg, c2_reg, root_val};

endmodule

>>> rtl/nss_fifo.sv
// ============================================================================
// nss_fifo
// Two-entry queue between the classifying front end and the search engine.
// ============================================================================
module nss_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

>>> rtl/nss_back.sv
// ============================================================================
// nss_back
// Search engine: bit-serial square and square-root quotient per classified
// segment, unit direction of a new best, running minimum and result register.
// ============================================================================
module nss_back #(
    parameter int COORD_BITS = 24
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [4*(2*COORD_BITS+2)+2+nss_pkg::CTRL_BITS-1:0] in_data,
    output logic out_valid,
    input  logic out_ready,
    output logic found,
    output logic [nss_pkg::DIST_BITS-1:0] distance,
    output logic signed [nss_pkg::DIR_BITS-1:0] dir_x,
    output logic signed [nss_pkg::DIR_BITS-1:0] dir_y,
    output logic [nss_pkg::KIND_BITS-1:0] nearest_kind
);

    localparam int MW = 2 * COORD_BITS + 2;
    localparam int WW = 2 * MW + 52;
    localparam int CW = $clog2(MW);
    localparam int DB = nss_pkg::DIST_BITS;
    localparam int RB = nss_pkg::DIR_BITS;

    logic [MW-1:0]       in_root, in_c2, in_vx2, in_vy2;
    logic                in_sx, in_sy;
    nss_pkg::item_ctrl_t in_ctrl;

    nss_pkg::back_state_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [WW-1:0]   num_reg, num_next;
    logic [WW-1:0]   a_reg, a_next, b_reg, b_next;
    logic [WW-1:0]   bs_reg, bs_next, ls_reg, ls_next, lb_reg, lb_next;
    logic [WW-1:0]   mc_reg, mc_next;
    logic [MW-1:0]   mr_reg, mr_next;
    logic [DB-1:0]   res_reg, res_next;
    logic [DB-1:0]   d_reg, d_next;
    logic signed [RB-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic            upd_reg, upd_next;
    logic [MW-1:0]   c2_reg, c2_next, vx2_reg, vx2_next, vy2_reg, vy2_next;
    logic            sx_reg, sx_next, sy_reg, sy_next;
    nss_pkg::item_ctrl_t ctrl_reg, ctrl_next;

    logic [DB-1:0]   best_dist_reg, best_dist_next;
    logic signed [RB-1:0] best_dx_reg, best_dx_next, best_dy_reg, best_dy_next;
    logic [nss_pkg::KIND_BITS-1:0] best_kind_reg, best_kind_next;
    logic            best_found_reg, best_found_next;

    logic            out_valid_reg, out_valid_next;
    logic            out_found_reg, out_found_next;
    logic [DB-1:0]   out_dist_reg, out_dist_next;
    logic signed [RB-1:0] out_dx_reg, out_dx_next, out_dy_reg, out_dy_next;
    logic [nss_pkg::KIND_BITS-1:0] out_kind_reg, out_kind_next;

    logic [WW-1:0]   t1, t2, kval, cand, sq_sum, len2;
    logic            take;
    logic [DB-1:0]   res_step;
    logic signed [RB-1:0] mag_dir;

    assign in_root = in_data[MW-1:0];
    assign in_c2   = in_data[2*MW-1:MW];
    assign in_vx2  = in_data[3*MW-1:2*MW];
    assign in_vy2  = in_data[4*MW-1:3*MW];
    assign in_sx   = in_data[4*MW];
    assign in_sy   = in_data[4*MW+1];
    assign in_ctrl = nss_pkg::item_ctrl_t'(in_data[4*MW+2 +: nss_pkg::CTRL_BITS]);

    assign in_ready = (state_reg == nss_pkg::ST_IDLE);

    assign len2     = WW'(c2_reg);
    assign t2       = a_reg + bs_reg + ls_reg;
    assign t1       = b_reg + lb_reg;
    assign kval     = (t2 << 2) - (t1 << 2) + len2;
    assign cand     = (state_reg == nss_pkg::ST_ROOT) ? t2 : kval;
    assign take     = (cand <= num_reg);
    assign res_step = take ? (res_reg | (DB'(1) << cnt_reg)) : res_reg;
    assign mag_dir  = RB'(res_step[nss_pkg::DIR_STEPS-1:0]);
    assign sq_sum   = mr_reg[0] ? (num_reg + mc_reg) : num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= nss_pkg::ST_IDLE;
            out_valid_reg  <= 1'b0;
            best_dist_reg  <= nss_pkg::DIST_MAX;
            best_dx_reg    <= nss_pkg::DIR_ONE;
            best_dy_reg    <= '0;
            best_kind_reg  <= '0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            best_dist_reg  <= best_dist_next;
            best_dx_reg    <= best_dx_next;
            best_dy_reg    <= best_dy_next;
            best_kind_reg  <= best_kind_next;
            best_found_reg <= best_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        num_reg       <= num_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        bs_reg        <= bs_next;
        ls_reg        <= ls_next;
        lb_reg        <= lb_next;
        mc_reg        <= mc_next;
        mr_reg        <= mr_next;
        res_reg       <= res_next;
        d_reg         <= d_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        upd_reg       <= upd_next;
        c2_reg        <= c2_next;
        vx2_reg       <= vx2_next;
        vy2_reg       <= vy2_next;
        sx_reg        <= sx_next;
        sy_reg        <= sy_next;
        ctrl_reg      <= ctrl_next;
        out_found_reg <= out_found_next;
        out_dist_reg  <= out_dist_next;
        out_dx_reg    <= out_dx_next;
        out_dy_reg    <= out_dy_next;
        out_kind_reg  <= out_kind_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        num_next        = num_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        bs_next         = bs_reg;
        ls_next         = ls_reg;
        lb_next         = lb_reg;
        mc_next         = mc_reg;
        mr_next         = mr_reg;
        res_next        = res_reg;
        d_next          = d_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        upd_next        = upd_reg;
        c2_next         = c2_reg;
        vx2_next        = vx2_reg;
        vy2_next        = vy2_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        ctrl_next       = ctrl_reg;
        best_dist_next  = best_dist_reg;
        best_dx_next    = best_dx_reg;
        best_dy_next    = best_dy_reg;
        best_kind_next  = best_kind_reg;
        best_found_next = best_found_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_found_next  = out_found_reg;
        out_dist_next   = out_dist_reg;
        out_dx_next     = out_dx_reg;
        out_dy_next     = out_dy_reg;
        out_kind_next   = out_kind_reg;

        case (state_reg)
            nss_pkg::ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    c2_next   = in_c2;
                    vx2_next  = in_vx2;
                    vy2_next  = in_vy2;
                    sx_next   = in_sx;
                    sy_next   = in_sy;
                    ctrl_next = in_ctrl;
                    upd_next  = 1'b0;
                    if (in_ctrl.first)
                    begin
                        best_dist_next  = nss_pkg::DIST_MAX;
                        best_dx_next    = nss_pkg::DIR_ONE;
                        best_dy_next    = '0;
                        best_kind_next  = '0;
                        best_found_next = 1'b0;
                    end
                    if (!in_ctrl.has_seg)
                    begin
                        state_next = nss_pkg::ST_DONE;
                    end
                    else if (in_ctrl.perp)
                    begin
                        num_next   = '0;
                        mc_next    = WW'(in_root);
                        mr_next    = in_root;
                        cnt_next   = CW'(MW - 1);
                        state_next = nss_pkg::ST_SQUARE;
                    end
                    else
                    begin
                        num_next   = WW'(in_root);
                        a_next     = '0;
                        b_next     = '0;
                        bs_next    = '0;
                        lb_next    = '0;
                        ls_next    = WW'(1) << (2 * (DB - 1));
                        res_next   = '0;
                        cnt_next   = CW'(DB - 1);
                        state_next = nss_pkg::ST_ROOT;
                    end
                end
            end

            nss_pkg::ST_SQUARE:
            begin
                num_next = sq_sum;
                mc_next  = mc_reg << 1;
                mr_next  = mr_reg >> 1;
                if (cnt_reg == '0)
                begin
                    a_next     = '0;
                    b_next     = '0;
                    bs_next    = '0;
                    lb_next    = '0;
                    ls_next    = len2 << (2 * (DB - 1));
                    res_next   = '0;
                    cnt_next   = CW'(DB - 1);
                    state_next = nss_pkg::ST_ROOT;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end

            nss_pkg::ST_ROOT, nss_pkg::ST_DIRX, nss_pkg::ST_DIRY:
            begin
                res_next = res_step;
                if (take)
                begin
                    a_next  = t2;
                    b_next  = t1;
                    bs_next = (bs_reg + (ls_reg << 1)) >> 1;
                end
                else
                begin
                    bs_next = bs_reg >> 1;
                end
                ls_next = ls_reg >> 2;
                lb_next = lb_reg >> 1;
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
                else
                begin
                    a_next   = '0;
                    b_next   = '0;
                    bs_next  = '0;
                    ls_next  = len2 << (2 * (nss_pkg::DIR_STEPS - 1));
                    lb_next  = len2 << (nss_pkg::DIR_STEPS - 1);
                    res_next = '0;
                    cnt_next = CW'(nss_pkg::DIR_STEPS - 1);
                    case (state_reg)
                        nss_pkg::ST_ROOT:
                        begin
                            d_next   = res_step;
                            upd_next = !best_found_reg || (res_step < best_dist_reg);
                            num_next = WW'(vx2_reg) << nss_pkg::DIR_SHIFT;
                            if (!upd_next)
                            begin
                                state_next = nss_pkg::ST_DONE;
                            end
                            else if (c2_reg == '0)
                            begin
                                dx_next    = '0;
                                dy_next    = '0;
                                state_next = nss_pkg::ST_DONE;
                            end
                            else
                            begin
                                state_next = nss_pkg::ST_DIRX;
                            end
                        end
                        nss_pkg::ST_DIRX:
                        begin
                            dx_next    = sx_reg ? -mag_dir : mag_dir;
                            num_next   = WW'(vy2_reg) << nss_pkg::DIR_SHIFT;
                            state_next = nss_pkg::ST_DIRY;
                        end
                        default:
                        begin
                            dy_next    = sy_reg ? -mag_dir : mag_dir;
                            state_next = nss_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            nss_pkg::ST_DONE:
            begin
                if (ctrl_reg.last && out_valid_reg && !out_ready)
                begin
                    state_next = nss_pkg::ST_DONE;
                end
                else
                begin
                    if (upd_reg)
                    begin
                        best_dist_next  = d_reg;
                        best_dx_next    = dx_reg;
                        best_dy_next    = dy_reg;
                        best_kind_next  = ctrl_reg.kind;
                        best_found_next = 1'b1;
                    end
                    if (ctrl_reg.last)
                    begin
                        out_valid_next = 1'b1;
                        out_found_next = best_found_next;
                        out_dist_next  = best_dist_next;
                        out_dx_next    = best_dx_next;
                        out_dy_next    = best_dy_next;
                        out_kind_next  = best_kind_next;
                    end
                    state_next = nss_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = nss_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign found        = out_found_reg;
    assign distance     = out_dist_reg;
    assign dir_x        = out_dx_reg;
    assign dir_y        = out_dy_reg;
    assign nearest_kind = out_kind_reg;

endmodule

>>> rtl/nearest_segment_search.sv
// ============================================================================
// nearest_segment_search
// Finds the segment of a stream nearest to a query point.
// ============================================================================
// Each input beat carries the query point, one segment and its road type;
// tuser marks whether the beat holds a segment and whether it starts a new
// search, tlast ends the search. One output beat follows each tlast beat with
// the found flag, the minimum distance, the unit direction and the road type
// of the nearest segment.
// A front pipeline forms the geometric terms and classifies each segment,
// then writes it to a two-entry queue. The search engine takes one item at
// a time: a bit-serial root gives an endpoint distance, a serial square
// comes first when the perpendicular distance is needed, and two 15-step
// direction roots follow when the segment becomes the new best.
// Reset empties the pipeline and queue and sets the running best to
// "nothing found". When the receiver stalls, the result stays in the output
// register, the engine goes on until it has a further result to hand over,
// and the front keeps taking beats until the queue is full.
// ============================================================================
module nearest_segment_search #(
    parameter int COORD_BITS = 24
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // query_x, query_y, seg_ax, seg_ay, seg_bx, seg_by
    input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // road_kind, has_segment, first_item
    input  logic [5:0] s_axis_tuser,
    input  logic s_axis_tlast,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // distance, dir_x, dir_y
    output logic [63:0] m_axis_tdata,
    // found, nearest_kind
    output logic [4:0] m_axis_tuser
);

    localparam int C  = COORD_BITS;
    localparam int MW = 2 * COORD_BITS + 2;
    localparam int QW = 4 * MW + 2 + nss_pkg::CTRL_BITS;

    logic          f_valid, f_ready, b_valid, b_ready;
    logic [QW-1:0] f_data, b_data;
    logic          found;
    logic [nss_pkg::DIST_BITS-1:0]       distance;
    logic signed [nss_pkg::DIR_BITS-1:0] dir_x, dir_y;
    logic [nss_pkg::KIND_BITS-1:0]       nearest_kind;

    nss_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .query_x     (s_axis_tdata[0*C +: C]),
        .query_y     (s_axis_tdata[1*C +: C]),
        .seg_ax      (s_axis_tdata[2*C +: C]),
        .seg_ay      (s_axis_tdata[3*C +: C]),
        .seg_bx      (s_axis_tdata[4*C +: C]),
        .seg_by      (s_axis_tdata[5*C +: C]),
        .road_kind   (s_axis_tuser[3:0]),
        .has_segment (s_axis_tuser[4]),
        .first_item  (s_axis_tuser[5]),
        .last_item   (s_axis_tlast),
        .out_valid   (f_valid),
        .out_ready   (f_ready),
        .out_data    (f_data)
    );

    nss_fifo #(
        .WIDTH(QW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    nss_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (b_valid),
        .in_ready     (b_ready),
        .in_data      (b_data),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .found        (found),
        .distance     (distance),
        .dir_x        (dir_x),
        .dir_y        (dir_y),
        .nearest_kind (nearest_kind)
    );

    assign m_axis_tdata = {7'd0, dir_y, dir_x, distance};
    assign m_axis_tuser = {nearest_kind, found};

endmodule

>>> tb/nearest_segment_search_test.sv
`timescale 1ns / 1ps
// ============================================================================
// nearest_segment_search_test
// Self-checking testbench for the nearest segment search block.
// ============================================================================
// A queue of input beats, filled at time zero with directed searches and then
// random ones, feeds a clocked driver. Each accepted beat updates a local
// model of the running best, and each tlast beat adds one expected result.
// A clocked monitor compares every output beat with the oldest expected
// result. Both sides idle at random, the receiver holds off for a long
// stretch once, and the sender waits for the block to drain more than once.
// ============================================================================
module nearest_segment_search_test;

    localparam int  CB        = 24;
    localparam int  DW        = ((6*CB+7)/8)*8;
    localparam int  LIMIT     = 3000000;
    localparam int  QUIET_LO  = 4000;
    localparam int  QUIET_HI  = 14000;
    localparam int  HOLD_AT   = 2000;
    localparam int  HOLD_LEN  = 700;

    typedef logic signed [CB-1:0] coord_t;

    typedef struct {
        logic [DW-1:0] data;
        logic [5:0]    user;
        logic          last;
        bit            drain_first;
    } seg_beat_t;

    typedef struct {
        logic                                 found;
        logic [nss_pkg::DIST_BITS-1:0]        min_dist;
        logic signed [nss_pkg::DIR_BITS-1:0]  dir_x;
        logic signed [nss_pkg::DIR_BITS-1:0]  dir_y;
        logic [nss_pkg::KIND_BITS-1:0]        kind;
    } nearest_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [DW-1:0] s_axis_tdata = '0;
    logic [5:0] s_axis_tuser = '0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [4:0] m_axis_tuser;

    seg_beat_t pending_beats[$];
    nearest_t  expected_nearest[$];
    seg_beat_t beat_on_bus;
    nearest_t  running_best;
    int        cycles = 0;
    int        mismatches = 0;
    int        hold_left = 0;

    nearest_segment_search #(.COORD_BITS(CB)) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always #4 clk = ~clk;

    function automatic logic [nss_pkg::DIST_BITS-1:0] root_of_ratio(logic [127:0] num,
                                                                   logic [127:0] den);
        logic [nss_pkg::DIST_BITS-1:0] d;
        logic [nss_pkg::DIST_BITS-1:0] t;
        d = '0;
        for (int b = nss_pkg::DIST_BITS - 1; b >= 0; b--) begin
            t = d | (nss_pkg::DIST_BITS'(1) << b);
            if ((128'(t) * 128'(t)) * den <= num)
                d = t;
        end
        return d;
    endfunction

    function automatic logic signed [nss_pkg::DIR_BITS-1:0] unit_component(
        longint c, logic [127:0] len2);
        logic [127:0] m;
        logic [127:0] num;
        logic [127:0] k;
        int n;
        int t;
        if (len2 == 0)
            return '0;
        m = c < 0 ? 128'(-c) : 128'(c);
        num = (m * m) << nss_pkg::DIR_SHIFT;
        n = 0;
        for (int b = nss_pkg::DIR_STEPS - 1; b >= 0; b--) begin
            t = n | (1 << b);
            k = 128'(2 * t - 1);
            if (k * k * len2 <= num)
                n = t;
        end
        return c < 0 ? nss_pkg::DIR_BITS'(-n) : nss_pkg::DIR_BITS'(n);
    endfunction

    function automatic void clear_best();
        running_best.found    = 1'b0;
        running_best.min_dist = nss_pkg::DIST_MAX;
        running_best.dir_x    = nss_pkg::DIR_ONE;
        running_best.dir_y    = '0;
        running_best.kind     = '0;
    endfunction

    function automatic void track_nearest(seg_beat_t sb);
        longint px, py, ax, ay, bx, by, vx, vy, wx, wy, ex, ey, c1, c2, cr;
        logic [127:0] s;
        logic [nss_pkg::DIST_BITS-1:0] d;
        px = longint'(coord_t'(sb.data[0*CB +: CB]));
        py = longint'(coord_t'(sb.data[1*CB +: CB]));
        ax = longint'(coord_t'(sb.data[2*CB +: CB]));
        ay = longint'(coord_t'(sb.data[3*CB +: CB]));
        bx = longint'(coord_t'(sb.data[4*CB +: CB]));
        by = longint'(coord_t'(sb.data[5*CB +: CB]));
        if (sb.user[5])
            clear_best();
        if (sb.user[4]) begin
            vx = bx - ax;
            vy = by - ay;
            wx = px - ax;
            wy = py - ay;
            c1 = wx * vx + wy * vy;
            c2 = vx * vx + vy * vy;
            if (c1 <= 0) begin
                s = 128'(wx * wx) + 128'(wy * wy);
                d = root_of_ratio(s, 128'd1);
            end else if (c2 <= c1) begin
                ex = px - bx;
                ey = py - by;
                s = 128'(ex * ex) + 128'(ey * ey);
                d = root_of_ratio(s, 128'd1);
            end else begin
                cr = vx * wy - vy * wx;
                s = cr < 0 ? 128'(-cr) : 128'(cr);
                d = root_of_ratio(s * s, 128'(c2));
            end
            if (!running_best.found || d < running_best.min_dist) begin
                running_best.found    = 1'b1;
                running_best.min_dist = d;
                running_best.dir_x    = unit_component(vx, 128'(c2));
                running_best.dir_y    = unit_component(vy, 128'(c2));
                running_best.kind     = sb.user[3:0];
            end
        end
        if (sb.last)
            expected_nearest = {expected_nearest, running_best};
    endfunction

    function automatic void add_beat(int qx, int qy, int ax, int ay,
                                     int bx, int by, logic [3:0] kind,
                                     bit has, bit first, bit last, bit drain = 1'b0);
        seg_beat_t sb;
        sb.data = {coord_t'(by), coord_t'(bx), coord_t'(ay), coord_t'(ax),
                   coord_t'(qy), coord_t'(qx)};
        sb.user = {first, has, kind};
        sb.last = last;
        sb.drain_first = drain;
        pending_beats = {pending_beats, sb};
    endfunction

    function automatic coord_t any_coord(coord_t centre);
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: return coord_t'(24'h800000);
                    1: return coord_t'(24'h7fffff);
                    2: return '0;
                    default: return '1;
                endcase
            end
            1, 2, 3: return coord_t'($urandom);
            default: return coord_t'(int'(centre) + int'($urandom_range(4000)) - 2000);
        endcase
    endfunction

    function automatic void random_search(bit drain);
        coord_t qx, qy, ax, ay, bx, by;
        int n;
        bit first;
        qx = any_coord(coord_t'(int'($urandom_range(20000)) - 10000));
        qy = any_coord(coord_t'(int'($urandom_range(20000)) - 10000));
        n = $urandom_range(1, 7);
        first = $urandom_range(9) != 0;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(5) != 0 || i == 0) begin
                ax = any_coord(qx);
                ay = any_coord(qy);
                bx = any_coord(qx);
                by = any_coord(qy);
                if ($urandom_range(15) == 0) begin
                    bx = ax;
                    by = ay;
                end
            end
            add_beat(int'(qx), int'(qy), int'(ax), int'(ay), int'(bx), int'(by),
                     4'($urandom), $urandom_range(7) != 0,
                     i == 0 ? first : ($urandom_range(29) == 0), i == n - 1,
                     i == 0 ? drain : 1'b0);
        end
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("** nearest_segment_search: FAILED **");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            s_axis_tlast  <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                track_nearest(beat_on_bus);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_beats.size() > 0
                    && !(pending_beats[0].drain_first && expected_nearest.size() > 0)
                    && !(($urandom_range(99) < 33)
                         && !(cycles > QUIET_LO && cycles < QUIET_HI))) begin
                    beat_on_bus = pending_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= beat_on_bus.data;
                    s_axis_tuser  <= beat_on_bus.user;
                    s_axis_tlast  <= beat_on_bus.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_left <= 0;
        end else begin
            if (cycles == HOLD_AT)
                hold_left <= HOLD_LEN;
            else if (hold_left > 0)
                hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= (hold_left == 0 && cycles != HOLD_AT)
                && (($urandom_range(99) >= 33) || (cycles > QUIET_LO && cycles < QUIET_HI));
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_nearest.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected output beat: tdata=%h tuser=%h",
                                 m_axis_tdata, m_axis_tuser);
                end else begin
                    nearest_t e;
                    e = expected_nearest.pop_front();
                    if (m_axis_tuser[0] !== e.found || m_axis_tuser[4:1] !== e.kind
                        || m_axis_tdata[24:0] !== e.min_dist
                        || m_axis_tdata[40:25] !== e.dir_x
                        || m_axis_tdata[56:41] !== e.dir_y) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Mismatch: expected found=%0d dist=%0d dir=(%0d,%0d) ",
                                      "kind=%0d, got found=%0d dist=%0d dir=(%0d,%0d) kind=%0d"},
                                     e.found, e.min_dist, e.dir_x, e.dir_y, e.kind,
                                     m_axis_tuser[0], m_axis_tdata[24:0],
                                     $signed(m_axis_tdata[40:25]),
                                     $signed(m_axis_tdata[56:41]), m_axis_tuser[4:1]);
                    end
                end
            end
        end
    end

    initial
    begin
        int mx;
        int mn;
        mx = 8388607;
        mn = -8388608;
        clear_best();
        // Nothing found since reset, then a marker-only search.
        add_beat(0, 0, 0, 0, 0, 0, 4'd0, 1'b0, 1'b0, 1'b1);
        add_beat(5, 5, 1, 1, 2, 2, 4'd3, 1'b0, 1'b1, 1'b1);
        // Opposite corners of the coordinate range.
        add_beat(mx, mx, mn, mn, mn, mx, 4'hf, 1'b1, 1'b1, 1'b0);
        add_beat(mx, mx, mn, mx, mx, mn, 4'h1, 1'b1, 1'b0, 1'b1);
        add_beat(mn, mx, mx, mn, mx, mn, 4'h5, 1'b1, 1'b1, 1'b1);
        // Projection before A on two segments, then onto the segment.
        add_beat(0, 0, 256, 256, 2560, 512, 4'd2, 1'b1, 1'b1, 1'b0);
        add_beat(0, 0, -256, -512, -2560, -768, 4'd4, 1'b1, 1'b0, 1'b0);
        add_beat(0, 0, -1000, 300, 1000, 300, 4'd6, 1'b1, 1'b0, 1'b1);
        // Zero-length segment, then a tie where the earlier segment stays.
        add_beat(100, 100, 50, 60, 50, 60, 4'd7, 1'b1, 1'b1, 1'b0);
        add_beat(100, 100, 50, 60, 50, 60, 4'd8, 1'b1, 1'b0, 1'b1);
        add_beat(0, 0, 10, -5, 10, 5, 4'd9, 1'b1, 1'b1, 1'b0);
        add_beat(0, 0, -10, 5, -10, -5, 4'd10, 1'b1, 1'b0, 1'b1);
        // The running best carries on without a first beat.
        add_beat(0, 0, 40, 40, 50, 50, 4'd11, 1'b1, 1'b0, 1'b1);
        // Sender waits for the block to drain before this search.
        add_beat(-1, -1, mx, 0, mn, 0, 4'd12, 1'b1, 1'b1, 1'b0, 1'b1);
        add_beat(-1, -1, 0, 0, 0, 0, 4'd13, 1'b0, 1'b0, 1'b1);
        add_beat(7, -7, 3, 4, 3, 400, 4'd14, 1'b1, 1'b1, 1'b1);
        for (int i = 0; i < 410; i++)
            random_search(i % 60 == 59);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_beats.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_nearest.size() > 0)
            @(posedge clk);
        repeat (3 * CB + 100) @(posedge clk);
        if (mismatches == 0 && expected_nearest.size() == 0)
            $display("** nearest_segment_search: PASSED **");
        else
            $display("** nearest_segment_search: FAILED **");
        $finish;
    end

endmodule

>>> nearest_segment_search.f
rtl/nss_pkg.sv
rtl/nss_front.sv
rtl/nss_fifo.sv
rtl/nss_back.sv
rtl/nearest_segment_search.sv
tb/nearest_segment_search_test.sv
